// ===== rtl/msc_pkg.sv =====
// package: signature and class tables and compare functions for the magic signature classifier
package msc_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int SIG_COUNT    = 32;
  localparam int CLS_COUNT    = 15;
  localparam int PAT_BYTES    = 11;
  localparam int SIG_SPAN     = 16;
  localparam int POS_W        = 6;
  localparam int CLS_W        = 4;
  localparam int POS_HOLD     = (HEADER_BYTES < 63) ? HEADER_BYTES : 63;
  localparam int SIG_MP2T     = 28;
  localparam int CLS_AVI      = 0;

  localparam logic [31:0] MP2T_MASK = 32'hff4000df;

  // patterns right-justified: byte k sits at bits 8*(len-1-k)
  localparam logic [8*PAT_BYTES-1:0] SIG_PAT [SIG_COUNT] = '{
    "RIFF", "AVI", "ftypM4A", 16'hfffb, 16'hfffa, "ID3",
    32'h473fff10, 32'h000001b3, 32'h000001ba,
    "ftypmp41", "ftypmp42", "ftypisom", "ftypMSNV", "ftypM4V", "ftypf4v",
    32'h1a45dfa3, 32'h3026b275, "[Reference]",
    "mdat", "mdat", "moov", "ftypqt",
    "ftyp3g2", "ftyp3ge", "ftyp3gg", "ftyp3gp", "ftyp3gs",
    32'h464c5601, 32'h47400010, "WAV", 32'h89504e47, 16'hffd8
  };

  localparam int SIG_LEN [SIG_COUNT] = '{
    4, 3, 7, 2, 2, 3, 4, 4, 4, 8, 8, 8, 8, 7, 7, 4,
    4, 11, 4, 4, 4, 6, 7, 7, 7, 7, 7, 4, 4, 3, 4, 2
  };

  localparam int SIG_OFF [SIG_COUNT] = '{
    0, 8, 4, 0, 0, 0, 0, 0, 0, 4, 4, 4, 4, 4, 4, 0,
    0, 0, 12, 4, 4, 4, 4, 4, 4, 4, 4, 0, 0, 8, 0, 0
  };

  localparam int CLS_FIRST [CLS_COUNT] = '{
    0, 2, 3, 6, 9, 15, 16, 18, 22, 23, 27, 28, 29, 30, 31
  };

  localparam int CLS_CNT [CLS_COUNT] = '{
    2, 1, 3, 3, 6, 1, 2, 4, 1, 4, 1, 1, 1, 1, 1
  };

  typedef struct packed {
    logic             found;
    logic [CLS_W-1:0] class_index;
  } msc_result_t;

  function automatic logic byte_ok(input int sig, input int pos, input logic [7:0] b);
    int                      k;
    logic [8*PAT_BYTES-1:0]  pat;
    logic [7:0]              want;
    logic [7:0]              msk;
    logic                    ok;
    k    = pos - SIG_OFF[sig];
    pat  = SIG_PAT[sig];
    ok   = 1'b1;
    want = 8'h00;
    msk  = 8'hff;
    if (k >= 0 && k < SIG_LEN[sig]) begin
      want = pat[8*(SIG_LEN[sig]-1-k) +: 8];
      if (sig == SIG_MP2T) begin
        msk = MP2T_MASK[8*(SIG_LEN[sig]-1-k) +: 8];
      end
      ok = ((b & msk) == want);
    end
    return ok;
  endfunction

  // all positions from p on read as zero bytes
  function automatic logic tail_ok(input int sig, input logic [POS_W-1:0] p);
    logic ok;
    ok = 1'b1;
    for (int q = 0; q < SIG_SPAN; q++) begin
      if (q >= int'(p) && q < HEADER_BYTES) begin
        ok = ok & byte_ok(sig, q, 8'h00);
      end
    end
    return ok;
  endfunction

  function automatic logic [SIG_COUNT-1:0] cls_bits(input int c);
    logic [SIG_COUNT-1:0] m;
    m = '0;
    for (int i = 0; i < SIG_COUNT; i++) begin
      if (i >= CLS_FIRST[c] && i < CLS_FIRST[c] + CLS_CNT[c]) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/magic_signature_classifier_core.sv =====
// top level: header byte stream in, one file class result per header out
//
// in_*: one header byte per transaction in file order; in_tlast marks the
// final byte of a header. Positions missing from a short header are read
// as zero bytes; bytes beyond the header window are ignored.
// out_*: one transaction per header, carrying a found flag and the index of
// the first matching class (0 when nothing matched).
// Throughput: one byte per cycle while in_tready is high. All 32 signature
// compares and the class priority pick are combinational on the position and
// match-flag registers; the result is registered into the output register (or
// the skid register while the output register is full) as the last byte is taken.
// A two-entry output buffer (output register plus skid register) lets input
// continue while one result waits; in_tready drops only when both entries
// are full.
// Reset (rst_n low, synchronous) clears the position, sets all match flags
// and empties the output buffer. After each last byte the position and
// flags return to their reset values so the next byte starts a new header.
module magic_signature_classifier_core import msc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] header_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] found, [4:1] class_index, [7:5] zero
);

  logic [POS_W-1:0]     pos_r;
  logic [SIG_COUNT-1:0] alive_r;
  logic [POS_W-1:0]     pos_step;
  logic [SIG_COUNT-1:0] alive_step;
  msc_result_t          result;
  msc_result_t          out_data_r;
  msc_result_t          skid_data_r;
  logic                 out_valid_r;
  logic                 skid_valid_r;
  logic                 in_take;
  logic                 push;
  logic                 pop;

  msc_matcher u_matcher (
    .pos         (pos_r),
    .alive       (alive_r),
    .header_byte (in_tdata),
    .pos_step    (pos_step),
    .alive_step  (alive_step),
    .result      (result)
  );

  assign in_tready  = !skid_valid_r;
  assign in_take    = in_tvalid && in_tready;
  assign push       = in_take && in_tlast;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.class_index, out_data_r.found};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= '1;
    end else if (in_take) begin
      if (in_tlast) begin
        pos_r   <= '0;
        alive_r <= '1;
      end else begin
        pos_r   <= pos_step;
        alive_r <= alive_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= result;
      end else begin
        out_data_r  <= result;
      end
    end else if (push) begin
      skid_data_r <= result;
    end
  end

endmodule

// ===== rtl/msc_matcher.sv =====
// signature compare for one header byte, zero fill of a short header and class selection
module msc_matcher import msc_pkg::*; (
  input  logic [POS_W-1:0]     pos,
  input  logic [SIG_COUNT-1:0] alive,
  input  logic [7:0]           header_byte,
  output logic [POS_W-1:0]     pos_step,
  output logic [SIG_COUNT-1:0] alive_step,
  output msc_result_t          result
);

  logic [SIG_COUNT-1:0] alive_final;
  logic [CLS_COUNT-1:0] cls_hit;
  logic                 in_window;

  assign in_window = (int'(pos) < HEADER_BYTES);

  always_comb begin
    pos_step = pos;
    if (int'(pos) < POS_HOLD) begin
      pos_step = pos + POS_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < SIG_COUNT; i++) begin
      alive_step[i]  = alive[i] & (!in_window | byte_ok(i, int'(pos), header_byte));
      alive_final[i] = alive_step[i] & tail_ok(i, pos_step);
    end
  end

  always_comb begin
    for (int c = 0; c < CLS_COUNT; c++) begin
      if (c == CLS_AVI) begin
        cls_hit[c] = ((alive_final & cls_bits(c)) == cls_bits(c));
      end else begin
        cls_hit[c] = ((alive_final & cls_bits(c)) != '0);
      end
    end
  end

  always_comb begin
    result.found       = 1'b0;
    result.class_index = '0;
    for (int c = CLS_COUNT - 1; c >= 0; c--) begin
      if (cls_hit[c]) begin
        result.found       = 1'b1;
        result.class_index = CLS_W'(c);
      end
    end
  end

endmodule
